// ===== rtl/fwq_pkg.sv =====
// ----------------------------------------------------------------------------
// fwq_pkg: shared definitions for the futex wait queue engine
// Field widths, action codes, command and result types, state encodings.
// ----------------------------------------------------------------------------
package fwq_pkg;

   // default sizing of the waiter store
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int TASK_ID_BITS_DEF = 8;

   // fixed field widths
   localparam int ACTION_W  = 3;
   localparam int TASK_ID_W = 8;
   localparam int ADDR_W    = 64;
   localparam int LIMIT_W   = 8;
   localparam int COUNT_W   = 5;

   // depth of the command queue between front and back
   localparam int CMD_Q_DEPTH = 2;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_SLEEP     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_WAKE_N    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WAKE_ALL  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_WAKE_ADDR = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_COUNT     = 3'd4;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // decoded operation
   typedef enum logic [2:0] {
      OP_SLEEP,
      OP_WAKE_N,
      OP_WAKE_ALL,
      OP_WAKE_ADDR,
      OP_COUNT,
      OP_NONE
   } op_type;

   // command handed from front to back
   typedef struct packed {
      op_type               op;
      logic [TASK_ID_W-1:0] task_id;
      logic [ADDR_W-1:0]    wait_address;
      logic [LIMIT_W-1:0]   limit;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic [TASK_ID_W-1:0] woken_id;
      logic                 is_woken;
      logic [COUNT_W-1:0]   match_count;
      logic                 resched;
      logic                 status;
      logic                 last;
   } rsp_payload_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EVAL,
      BK_SUMMARY
   } back_state_type;

endpackage

// ===== rtl/fwq_channels.sv =====
// ----------------------------------------------------------------------------
// fwq channels: request and response stream interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fwq_req_if;
   logic                           valid;
   logic                           ready;
   logic [fwq_pkg::ACTION_W-1:0]   action;
   logic [fwq_pkg::TASK_ID_W-1:0]  task_id;
   logic [fwq_pkg::ADDR_W-1:0]     wait_address;
   logic [fwq_pkg::LIMIT_W-1:0]    limit;

   modport source (output valid, action, task_id, wait_address, limit, input ready);
   modport sink   (input valid, action, task_id, wait_address, limit, output ready);
endinterface

interface fwq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fwq_pkg::TASK_ID_W-1:0]  woken_id;
   logic                           is_woken;
   logic [fwq_pkg::COUNT_W-1:0]    match_count;
   logic                           resched;
   logic                           status;
   logic                           last;

   modport source (output valid, woken_id, is_woken, match_count, resched, status, last,
                   input ready);
   modport sink   (input valid, woken_id, is_woken, match_count, resched, status, last,
                   output ready);
endinterface

// ===== rtl/fwq_front.sv =====
// ----------------------------------------------------------------------------
// fwq_front: request intake and command queue
// Accepts request beats, decodes the action and holds the commands in a
// short queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module fwq_front (
   input  logic              clock,
   input  logic              reset,
   fwq_req_if.sink           req_bus,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output fwq_pkg::cmd_type  cmd
);

   localparam int PtrW = (fwq_pkg::CMD_Q_DEPTH > 1) ? $clog2(fwq_pkg::CMD_Q_DEPTH) : 1;
   localparam int FillW = $clog2(fwq_pkg::CMD_Q_DEPTH + 1);
   localparam logic [FillW-1:0] FullFill = FillW'(fwq_pkg::CMD_Q_DEPTH);
   localparam logic [PtrW-1:0]  LastPtr  = PtrW'(fwq_pkg::CMD_Q_DEPTH - 1);

   fwq_pkg::cmd_type  q_ff [fwq_pkg::CMD_Q_DEPTH];
   fwq_pkg::cmd_type  dec_cmd;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]  fill_ff, fill_in;
   logic              push, pop;

   // classify the incoming action
   always_comb begin
      dec_cmd.task_id      = req_bus.task_id;
      dec_cmd.wait_address = req_bus.wait_address;
      dec_cmd.limit        = req_bus.limit;
      case (req_bus.action)
         fwq_pkg::ACT_SLEEP:     dec_cmd.op = fwq_pkg::OP_SLEEP;
         fwq_pkg::ACT_WAKE_N:    dec_cmd.op = fwq_pkg::OP_WAKE_N;
         fwq_pkg::ACT_WAKE_ALL:  dec_cmd.op = fwq_pkg::OP_WAKE_ALL;
         fwq_pkg::ACT_WAKE_ADDR: dec_cmd.op = fwq_pkg::OP_WAKE_ADDR;
         fwq_pkg::ACT_COUNT:     dec_cmd.op = fwq_pkg::OP_COUNT;
         default:                dec_cmd.op = fwq_pkg::OP_NONE;
      endcase
   end

   // queue handshakes
   assign req_bus.ready = (fill_ff != FullFill);
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (fill_ff != '0);
   assign pop           = cmd_valid && cmd_ready;
   assign cmd           = q_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FillW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

// ===== rtl/fwq_back.sv =====
// ----------------------------------------------------------------------------
// fwq_back: wait queue execution
// Holds the waiter memory and occupancy, runs sleep, wake and count commands
// with an in-place compacting scan, and drives the response output register.
// ----------------------------------------------------------------------------
module fwq_back #(
   parameter int QUEUE_DEPTH  = fwq_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = fwq_pkg::TASK_ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  fwq_pkg::cmd_type  cmd,
   fwq_rsp_if.source         rsp_bus
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int CmpW = (CntW > fwq_pkg::LIMIT_W) ? CntW : fwq_pkg::LIMIT_W;
   localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

   // waiter memory
   logic [TASK_ID_BITS-1:0]       mem_id   [QUEUE_DEPTH];
   logic [fwq_pkg::ADDR_W-1:0]    mem_addr [QUEUE_DEPTH];
   logic                          wr_en, rd_en;
   logic [IdxW-1:0]               wr_idx, rd_idx;
   logic [TASK_ID_BITS-1:0]       wr_id;
   logic [fwq_pkg::ADDR_W-1:0]    wr_addr;
   logic [TASK_ID_BITS-1:0]       rd_id_ff;
   logic [fwq_pkg::ADDR_W-1:0]    rd_addr_ff;

   // sequencer state
   fwq_pkg::back_state_type       st_ff, st_in;
   fwq_pkg::op_type               op_ff, op_in;
   logic [fwq_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [fwq_pkg::LIMIT_W-1:0]   lim_ff, lim_in;
   logic [CntW-1:0]               occ_ff, occ_in;
   logic [CntW-1:0]               idx_ff, idx_in;
   logic [CntW-1:0]               keep_ff, keep_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic                          status_ff, status_in;

   // response register
   logic                          out_valid_ff, out_valid_in;
   fwq_pkg::rsp_payload_type      out_ff, out_in;
   logic                          out_load, out_free;

   // scan decision terms
   logic                          hit, under_lim, take;
   logic [CntW-1:0]               idx_next;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign hit       = (rd_addr_ff == addr_ff);
   assign under_lim = (op_ff == fwq_pkg::OP_WAKE_ALL) ||
                      (CmpW'(cnt_ff) < CmpW'(lim_ff));
   assign take      = (op_ff != fwq_pkg::OP_COUNT) && under_lim &&
                      ((op_ff != fwq_pkg::OP_WAKE_ADDR) || hit);
   assign idx_next  = idx_ff + CntW'(1);

   // next state and outputs
   always_comb begin
      st_in     = st_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      lim_in    = lim_ff;
      occ_in    = occ_ff;
      idx_in    = idx_ff;
      keep_in   = keep_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      wr_idx    = '0;
      wr_id     = rd_id_ff;
      wr_addr   = rd_addr_ff;
      rd_en     = 1'b0;
      rd_idx    = '0;
      out_load  = 1'b0;
      out_in    = out_ff;

      case (st_ff)
         fwq_pkg::BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in     = cmd.op;
               addr_in   = cmd.wait_address;
               lim_in    = cmd.limit;
               idx_in    = '0;
               keep_in   = '0;
               cnt_in    = '0;
               status_in = fwq_pkg::STATUS_OK;
               st_in     = fwq_pkg::BK_SUMMARY;
               case (cmd.op)
                  fwq_pkg::OP_SLEEP: begin
                     // append at the tail unless full
                     if (occ_ff >= DepthCnt) begin
                        status_in = fwq_pkg::STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_idx  = occ_ff[IdxW-1:0];
                        wr_id   = TASK_ID_BITS'(cmd.task_id);
                        wr_addr = cmd.wait_address;
                        occ_in  = occ_ff + CntW'(1);
                     end
                  end
                  fwq_pkg::OP_WAKE_N,
                  fwq_pkg::OP_WAKE_ALL,
                  fwq_pkg::OP_WAKE_ADDR,
                  fwq_pkg::OP_COUNT: begin
                     // start the scan at the head
                     if (occ_ff != '0) begin
                        rd_en  = 1'b1;
                        rd_idx = '0;
                        st_in  = fwq_pkg::BK_EVAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         fwq_pkg::BK_EVAL: begin
            // a woken entry waits for a free response slot
            if (!take || out_free) begin
               if (take) begin
                  out_load           = 1'b1;
                  out_in.woken_id    = fwq_pkg::TASK_ID_W'(rd_id_ff);
                  out_in.is_woken    = 1'b1;
                  out_in.match_count = '0;
                  out_in.resched     = 1'b0;
                  out_in.status      = fwq_pkg::STATUS_OK;
                  out_in.last        = 1'b0;
                  cnt_in             = cnt_ff + CntW'(1);
               end else if (op_ff == fwq_pkg::OP_COUNT) begin
                  cnt_in = cnt_ff + CntW'(hit);
               end else begin
                  // kept entry slides down to the compaction point
                  wr_en   = 1'b1;
                  wr_idx  = keep_ff[IdxW-1:0];
                  keep_in = keep_ff + CntW'(1);
               end
               idx_in = idx_next;
               if (idx_next < occ_ff) begin
                  rd_en  = 1'b1;
                  rd_idx = idx_next[IdxW-1:0];
               end else begin
                  st_in = fwq_pkg::BK_SUMMARY;
                  if (op_ff != fwq_pkg::OP_COUNT) begin
                     occ_in = take ? keep_ff : keep_ff + CntW'(1);
                  end
               end
            end
         end

         fwq_pkg::BK_SUMMARY: begin
            if (out_free) begin
               out_load           = 1'b1;
               out_in.woken_id    = '0;
               out_in.is_woken    = 1'b0;
               out_in.match_count = fwq_pkg::COUNT_W'(cnt_ff);
               out_in.resched     = (op_ff != fwq_pkg::OP_COUNT) && (cnt_ff != '0);
               out_in.status      = status_ff;
               out_in.last        = 1'b1;
               st_in              = fwq_pkg::BK_IDLE;
            end
         end

         default: begin
            st_in = fwq_pkg::BK_IDLE;
         end
      endcase

      // response valid tracking
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= fwq_pkg::BK_IDLE;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      lim_ff    <= lim_in;
      idx_ff    <= idx_in;
      keep_ff   <= keep_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   // waiter memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_id[wr_idx]   <= wr_id;
         mem_addr[wr_idx] <= wr_addr;
      end
      if (rd_en) begin
         rd_id_ff   <= mem_id[rd_idx];
         rd_addr_ff <= mem_addr[rd_idx];
      end
   end

   // response port
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.woken_id    = out_ff.woken_id;
   assign rsp_bus.is_woken    = out_ff.is_woken;
   assign rsp_bus.match_count = out_ff.match_count;
   assign rsp_bus.resched     = out_ff.resched;
   assign rsp_bus.status      = out_ff.status;
   assign rsp_bus.last        = out_ff.last;

endmodule

// ===== rtl/futex_wait_queue_engine_core.sv =====
// ----------------------------------------------------------------------------
// futex_wait_queue_engine_core: futex-style wait queue engine
// Ordered queue of sleeping task ids tagged with wait addresses; sleep, wake
// and count requests in, per-waiter and summary response beats out.
// ----------------------------------------------------------------------------
// Requests land in a two-entry command queue and run one at a time in the
// back end. A sleep or an unused action yields a single summary beat. A
// wake or count request scans the resident waiters through the registered
// read port of the waiter memory, one entry per cycle while no woken id
// waits for a free response slot; the response side holding ready low
// while woken ids are pending stalls the scan. Each wake emits one beat per
// woken id, oldest first, then a summary beat with last set. Up to two
// further requests are taken while one is running.
module futex_wait_queue_engine_core #(
   parameter int QUEUE_DEPTH  = fwq_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = fwq_pkg::TASK_ID_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fwq_req_if.sink   req_bus,
   fwq_rsp_if.source rsp_bus
);

   logic              cmd_valid;
   logic              cmd_ready;
   fwq_pkg::cmd_type  cmd;

   // intake and command queue
   fwq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // queue execution and responses
   fwq_back #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule
